[sv/slot_allocator_with_value_store_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef SLOT_ALLOCATOR_WITH_VALUE_STORE_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_VALUE_STORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/slotalloc_pkg.sv]
package slotalloc_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 64;
  localparam int GRANT_W    = 6;

  // two-level search: groups of eight flags
  localparam int GRP      = 8;
  localparam int NGRP     = (SLOT_COUNT + GRP - 1) / GRP;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam int IN_W     = 2 + IDX_W + VAL_W;
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W    = 2 + GRANT_W + VAL_W;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GET   = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // control from the sequencer to the value store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clr;
    logic [SLOT_W-1:0] addr;
  } store_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } free_hit_t;

  // lowest clear flag: first hit inside each group, then first group
  function automatic free_hit_t find_free(input logic [SLOT_COUNT-1:0] in_use);
    logic [NGRP-1:0]            grp_any;
    logic [NGRP-1:0][GRP_W-1:0] grp_pos;
    logic [SLOT_W-1:0]          full_idx;
    free_hit_t                  hit;
    int                         s;
    grp_any  = '0;
    grp_pos  = '0;
    full_idx = '0;
    hit      = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int b = GRP - 1; b >= 0; b--) begin
        s = g * GRP + b;
        if (s < SLOT_COUNT) begin
          if (!in_use[s]) begin
            grp_any[g] = 1'b1;
            grp_pos[g] = GRP_W'(b);
          end
        end
      end
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        full_idx = SLOT_W'(g * GRP) | SLOT_W'(grp_pos[g]);
        hit.found = 1'b1;
      end
    end
    hit.idx = full_idx;
    return hit;
  endfunction

endpackage

[sv/slotalloc_store.sv]
module slotalloc_store
  import slotalloc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  store_req_t       req,
  input  logic [VAL_W-1:0] wr_data,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0]      mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld;
  logic [VAL_W-1:0]      rd_q;
  logic                  rd_vld;

  // entries without a valid bit read as zero
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.addr] <= 1'b1;
      end else if (req.clr) begin
        vld[req.addr] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[sv/slot_allocator_with_value_store.sv]
// Slot allocator with a 64-bit value per slot.
// Input stream s_*: one request per transfer (allocate, free, get, set).
// Output stream m_*: exactly one result per request, in request order.
// Allocate grants the lowest free slot and zeroes its value; free releases
// an in-use slot; get and set read or write a value without looking at the
// in-use flag. Bad indices and frees of unused slots give an error status.
// Allocate, free, set and erroring requests show their result in the cycle
// after the input transfer; an in-range get passes through the value RAM's
// read register and then the output register. A new request is taken every
// cycle for non-get traffic while the receiver keeps up; none during a read.
// In-use flags live in flip-flops with a priority search; values live in a
// RAM whose per-entry valid bits make unwritten or released entries read as
// zero, so reset takes effect at once with no clearing sweep.
// Reset (rst, synchronous) empties the table and the output register.
// A stalled receiver holds the result in the output register; the next
// request is taken in the cycle the held result is transferred.
module slot_allocator_with_value_store
  import slotalloc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // [1:0] func, [9:2] slot_index, [73:10] write_value, rest zero
  input  logic [IN_TW-1:0]  s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // [1:0] status, [7:2] granted_slot, [71:8] read_value
  output logic [OUT_TW-1:0] m_tdata
);

`include "slot_allocator_with_value_store_macros.svh"

  state_t                state, state_next;
  logic [SLOT_COUNT-1:0] in_use;
  logic [SLOT_COUNT-1:0] in_use_next;

  op_t               op;
  logic [IDX_W-1:0]  slot_index;
  logic [VAL_W-1:0]  write_value;
  logic [SLOT_W-1:0] addr;
  logic              in_range;
  logic              accept;
  logic              is_read;
  logic              alloc_ok;
  logic              free_ok;
  free_hit_t         hit;

  status_t           req_status;
  logic [GRANT_W-1:0] req_grant;
  store_req_t        sreq;
  logic [VAL_W-1:0]  rd_data;

  // output register
  status_t            out_status;
  logic [GRANT_W-1:0] out_grant;
  logic [VAL_W-1:0]   out_value;

  assign op          = op_t'(s_tdata[1:0]);
  assign slot_index  = s_tdata[2 +: IDX_W];
  assign write_value = s_tdata[2 + IDX_W +: VAL_W];
  assign addr        = SLOT_W'(slot_index);
  assign in_range    = (32'(slot_index) < 32'(SLOT_COUNT));
  assign hit         = find_free(in_use);

  // state machine: next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (is_read) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state machine: outputs; the output register is free or drains this cycle
  always_comb begin
    s_tready = 1'b0;
    unique case (state)
      S_IDLE:  s_tready = !m_tvalid || m_tready;
      S_READ:  s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // request decode
  always_comb begin
    req_status  = STAT_OK;
    req_grant   = '0;
    in_use_next = in_use;
    sreq        = '0;
    sreq.addr   = addr;
    is_read     = 1'b0;
    alloc_ok    = 1'b0;
    free_ok     = 1'b0;
    if (accept) begin
      if (op == OP_ALLOC) begin
        if (hit.found) begin
          alloc_ok              = 1'b1;
          in_use_next[hit.idx]  = 1'b1;
          sreq.addr             = hit.idx;
          sreq.clr              = 1'b1;
          req_grant             = GRANT_W'(hit.idx);
        end else begin
          req_status = STAT_FULL;
        end
      end else if (!in_range) begin
        req_status = STAT_RANGE;
      end else begin
        unique case (op)
          OP_FREE: begin
            if (in_use[addr]) begin
              free_ok           = 1'b1;
              in_use_next[addr] = 1'b0;
              sreq.clr          = 1'b1;
            end else begin
              req_status = STAT_NOT_USED;
            end
          end
          OP_GET: begin
            is_read     = 1'b1;
            sreq.rd_en  = 1'b1;
          end
          OP_SET: begin
            sreq.wr_en = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
    end
  end

  // output register: a get result is loaded from the RAM in the read state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_READ) begin
      m_tvalid <= 1'b1;
    end else if (accept && !is_read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      out_status <= STAT_OK;
      out_grant  <= '0;
      out_value  <= rd_data;
    end else if (accept && !is_read) begin
      out_status <= req_status;
      out_grant  <= req_grant;
      out_value  <= '0;
    end
  end

  assign m_tdata = OUT_TW'({out_value, out_grant, out_status});

  slotalloc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .wr_data (write_value),
    .rd_data (rd_data)
  );

  // a pending read must never find a result still waiting
  `SA_ASSERT_IMP(a_read_slot_free, state == S_READ, !m_tvalid,
                 "read cycle with output register occupied")
  // the read result is presented right after the read cycle
  `SA_ASSERT_NXT(a_read_lands, state == S_READ, m_tvalid,
                 "get result missing after read cycle")
  // a granted slot is marked in use
  `SA_ASSERT_NXT(a_alloc_marks, alloc_ok, in_use[$past(hit.idx)],
                 "allocated slot not marked in use")
  // a released slot is marked free
  `SA_ASSERT_NXT(a_free_clears, free_ok, !in_use[$past(addr)],
                 "freed slot still marked in use")

endmodule
